// File: hdl/spg_pkg.sv
// Package for seven_speaker_pan_gains: widths, speaker ring, codes and the cosine ROM.
package spg_pkg;

    localparam int ANGLE_W       = 17;
    localparam int GAIN_W        = 16;
    localparam int ZONE_W        = 16;
    localparam int SPEAKER_COUNT = 7;
    localparam int SPK_IDX_W     = $clog2(SPEAKER_COUNT);

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic [ZONE_W-1:0]         zone_t;

    // Angles in 1/64 degree units
    localparam int FULL_TURN = 23040;
    localparam int THETA_W   = $clog2(FULL_TURN);
    localparam int WRAP_W    = ANGLE_W + 1;
    // Bias that makes every 17-bit angle positive without changing it modulo a turn
    localparam logic [WRAP_W-1:0] WRAP_BIAS  = WRAP_W'(3 * FULL_TURN);
    localparam logic [WRAP_W-1:0] WRAP_FOUR  = WRAP_W'(4 * FULL_TURN);
    localparam logic [WRAP_W-1:0] WRAP_TWO   = WRAP_W'(2 * FULL_TURN);
    localparam logic [WRAP_W-1:0] WRAP_ONE   = WRAP_W'(FULL_TURN);

    localparam logic [THETA_W-1:0] SPK_LB = THETA_W'(13440);
    localparam logic [THETA_W-1:0] SPK_LS = THETA_W'(17280);
    localparam logic [THETA_W-1:0] SPK_LF = THETA_W'(21120);
    localparam logic [THETA_W-1:0] SPK_RF = THETA_W'(1920);
    localparam logic [THETA_W-1:0] SPK_RS = THETA_W'(5760);
    localparam logic [THETA_W-1:0] SPK_RB = THETA_W'(9600);

    localparam int LONG_SPAN  = 3840;
    localparam int SHORT_SPAN = 1920;
    localparam int OFF_W      = $clog2(LONG_SPAN + 1);

    // Span index equals the index of its first speaker in the ring
    typedef enum logic [SPK_IDX_W-1:0] {
        SPAN_LB_LS,
        SPAN_LS_LF,
        SPAN_LF_C,
        SPAN_C_RF,
        SPAN_RF_RS,
        SPAN_RS_RB,
        SPAN_RB_LB
    } span_t;

    // f16 = off * 65536 / LONG_SPAN = off * 256 / 15, by reciprocal multiply
    localparam int FRAC_DIV    = LONG_SPAN / 256;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_VAL   = ((1 << RECIP_SHIFT) + FRAC_DIV - 1) / FRAC_DIV;
    localparam int RECIP_W     = $clog2(RECIP_VAL + 1);
    localparam int FRAC_SHIFT  = RECIP_SHIFT - 8;
    localparam int PROD_W      = OFF_W + RECIP_W;
    localparam int FRAC_W      = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    localparam logic [GAIN_W-1:0] UNITY_Q15 = GAIN_W'(32768);

    typedef enum logic [1:0] {
        LAW_LINEAR,
        LAW_START,
        LAW_END
    } law_t;

    // Cosine ROM
    localparam int COS_ENTRIES = 256;
    localparam int IDX_W       = $clog2(COS_ENTRIES);
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = (IDX_W + DIV_BITS - 1) / DIV_BITS;

    localparam logic [63:0]        PI_Q30  = 64'd3373259426;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    typedef logic [GAIN_W-1:0] cos_rom_t [COS_ENTRIES];

    // cos(pi*j/N) in Q30 for j up to N/2, Horner on the Taylor series
    function automatic logic signed [63:0] cos_half_q30(input int unsigned j);
        logic [63:0]        xq;
        logic [63:0]        u;
        logic [63:0]        u2;
        logic [63:0]        p;
        logic signed [63:0] t;
        int                 k;
        xq = (64'(j) << 30) / COS_ENTRIES;
        u  = (PI_Q30 * xq) >> 30;
        u2 = (u * u) >> 30;
        t  = ONE_Q30;
        for (k = 0; k < 6; k++)
        begin
            if (t < 0)
            begin
                t = '0;
            end
            p = (u2 * $unsigned(t)) >> 30;
            case (k)
                0:       p = p / 132;
                1:       p = p / 90;
                2:       p = p / 56;
                3:       p = p / 30;
                4:       p = p / 12;
                default: p = p / 2;
            endcase
            t = ONE_Q30 - $signed(p);
        end
        return t;
    endfunction

    function automatic logic [GAIN_W-1:0] rom_entry(input int unsigned i);
        logic               upper;
        logic signed [63:0] c;
        logic signed [63:0] v;
        logic signed [63:0] r;
        upper = (2 * i) > COS_ENTRIES;
        c = cos_half_q30(upper ? (COS_ENTRIES - i) : i);
        v = upper ? (ONE_Q30 - c) : (ONE_Q30 + c);
        if (v < 0)
        begin
            v = '0;
        end
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd32768)
        begin
            r = 64'sd32768;
        end
        return GAIN_W'(r);
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        int       i;
        for (i = 0; i < COS_ENTRIES; i++)
        begin
            rom[i] = rom_entry(i);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// File: hdl/spg_ifs.sv
// Channel interfaces for seven_speaker_pan_gains: angle, gains and zone register write.
interface spg_angle_if;
    logic            valid;
    logic            ready;
    spg_pkg::angle_t angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface spg_gain_if;
    logic           valid;
    logic           ready;
    spg_pkg::gain_t gain_left_back;
    spg_pkg::gain_t gain_left_side;
    spg_pkg::gain_t gain_left_front;
    spg_pkg::gain_t gain_center;
    spg_pkg::gain_t gain_right_front;
    spg_pkg::gain_t gain_right_side;
    spg_pkg::gain_t gain_right_back;

    modport source (output valid, output gain_left_back, output gain_left_side,
                    output gain_left_front, output gain_center, output gain_right_front,
                    output gain_right_side, output gain_right_back, input ready);
    modport sink   (input valid, input gain_left_back, input gain_left_side,
                    input gain_left_front, input gain_center, input gain_right_front,
                    input gain_right_side, input gain_right_back, output ready);
endinterface

interface spg_cfg_if;
    logic           valid;
    logic           ready;
    spg_pkg::zone_t solo_zone;

    modport source (output valid, output solo_zone, input ready);
    modport sink   (input valid, input solo_zone, output ready);
endinterface

// File: hdl/seven_speaker_pan_gains.sv
// Top level of seven_speaker_pan_gains: pipelined pairwise panning gains for a seven-speaker ring.
//
//  channel   dir   word
//  --------  ----  ------------------------------------------------
//  azimuth   in    angle, 17-bit signed, 1/64 degree
//  gains     out   seven Q1.15 gains, ring order LB LS LF C RF RS RB
//  cfg       in    solo_zone, Q0.16, always ready
//
//  One word per cycle while gains is not stalled; registered stages: wrap, span, fraction multiply,
//  zone test, four radix-4 divider stages for the ROM index, ROM read and gain placement.
//  Reset clears all stage valid bits and solo_zone.
//  Each stage holds while the stage after it is full and stalled; empty stages close up.
module seven_speaker_pan_gains (
    input  logic       clk,
    input  logic       rst_n,
    spg_angle_if.sink  azimuth,
    spg_cfg_if.sink    cfg,
    spg_gain_if.source gains
);
    import spg_pkg::*;

    localparam int ST_THETA   = 0;
    localparam int ST_SPAN    = 1;
    localparam int ST_FRAC    = 2;
    localparam int ST_ZONE    = 3;
    localparam int ST_OUT     = ST_ZONE + DIV_STAGES + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] en;

    zone_t zone_reg;

    logic [THETA_W-1:0] theta_reg;
    logic [THETA_W-1:0] theta_next;

    span_t            span_s1_reg;
    logic [OFF_W-1:0] off_reg;
    span_t            span_s1_next;
    logic [OFF_W-1:0] off_next;

    span_t             span_s2_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [PROD_W-1:0] prod;

    // divider slots: 0 is the zone test result, 1..DIV_STAGES the divider stages
    span_t            dv_span_reg [DIV_STAGES+1];
    law_t             dv_law_reg  [DIV_STAGES+1];
    gain_t            dv_lin_reg  [DIV_STAGES+1];
    zone_t            dv_rem_reg  [DIV_STAGES+1];
    logic [IDX_W-1:0] dv_quo_reg  [DIV_STAGES+1];
    zone_t            dv_rem_next [DIV_STAGES+1];
    logic [IDX_W-1:0] dv_quo_next [DIV_STAGES+1];
    law_t             law_next;

    gain_t gain_reg  [SPEAKER_COUNT];
    gain_t gain_next [SPEAKER_COUNT];

    // handshake
    always_comb
    begin
        en[ST_OUT] = !vld_reg[ST_OUT] || gains.ready;
        for (int k = ST_OUT - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign azimuth.ready = en[ST_THETA];
    assign cfg.ready     = 1'b1;
    assign gains.valid   = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            zone_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                zone_reg <= cfg.solo_zone;
            end
            if (en[ST_THETA])
            begin
                vld_reg[ST_THETA] <= azimuth.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: wrap into one turn
    always_comb
    begin
        logic [WRAP_W-1:0] w0;
        logic [WRAP_W-1:0] w1;
        logic [WRAP_W-1:0] w2;
        logic [WRAP_W-1:0] w3;
        w0 = {azimuth.angle[ANGLE_W-1], azimuth.angle} + WRAP_BIAS;
        w1 = (w0 >= WRAP_FOUR) ? (w0 - WRAP_FOUR) : w0;
        w2 = (w1 >= WRAP_TWO)  ? (w1 - WRAP_TWO)  : w1;
        w3 = (w2 >= WRAP_ONE)  ? (w2 - WRAP_ONE)  : w2;
        theta_next = w3[THETA_W-1:0];
    end

    // stage 1: first span in ring order that holds the angle
    always_comb
    begin
        logic [THETA_W-1:0] off_full;
        if (theta_reg == '0)
        begin
            span_s1_next = SPAN_LF_C;
            off_full     = THETA_W'(SHORT_SPAN);
        end
        else if (theta_reg > SPK_LF)
        begin
            span_s1_next = SPAN_LF_C;
            off_full     = theta_reg - SPK_LF;
        end
        else if (theta_reg > SPK_LS)
        begin
            span_s1_next = SPAN_LS_LF;
            off_full     = theta_reg - SPK_LS;
        end
        else if (theta_reg >= SPK_LB)
        begin
            span_s1_next = SPAN_LB_LS;
            off_full     = theta_reg - SPK_LB;
        end
        else if (theta_reg > SPK_RB)
        begin
            span_s1_next = SPAN_RB_LB;
            off_full     = theta_reg - SPK_RB;
        end
        else if (theta_reg > SPK_RS)
        begin
            span_s1_next = SPAN_RS_RB;
            off_full     = theta_reg - SPK_RS;
        end
        else if (theta_reg > SPK_RF)
        begin
            span_s1_next = SPAN_RF_RS;
            off_full     = theta_reg - SPK_RF;
        end
        else
        begin
            span_s1_next = SPAN_C_RF;
            off_full     = theta_reg;
        end
        // short spans scaled up to the long span
        if (span_s1_next == SPAN_LF_C || span_s1_next == SPAN_C_RF)
        begin
            off_next = OFF_W'(off_full << 1);
        end
        else
        begin
            off_next = OFF_W'(off_full);
        end
    end

    // stage 2: fraction across the span, unsigned Q1.16 up to 1.0
    assign prod = PROD_W'(off_reg) * PROD_W'(RECIP_VAL);

    // stage 3: zone test, then divider: index = distance * N / zone,
    // DIV_BITS quotient bits per stage
    always_comb
    begin
        logic             in_start;
        logic             in_end;
        logic [ZONE_W:0]  r2;
        zone_t            r;
        logic [IDX_W-1:0] q;
        in_start = frac_reg < {1'b0, zone_reg};
        in_end   = frac_reg > (FRAC_ONE - {1'b0, zone_reg});
        if (in_start)
        begin
            law_next       = LAW_START;
            dv_rem_next[0] = frac_reg[ZONE_W-1:0];
        end
        else if (in_end)
        begin
            law_next       = LAW_END;
            dv_rem_next[0] = ZONE_W'(FRAC_ONE - frac_reg);
        end
        else
        begin
            law_next       = LAW_LINEAR;
            dv_rem_next[0] = frac_reg[ZONE_W-1:0];
        end
        dv_quo_next[0] = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            r = dv_rem_reg[s];
            q = dv_quo_reg[s];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                if (s * DIV_BITS + j < IDX_W)
                begin
                    r2 = {r, 1'b0};
                    if (r2 >= {1'b0, zone_reg})
                    begin
                        r = ZONE_W'(r2 - {1'b0, zone_reg});
                        q = {q[IDX_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = r2[ZONE_W-1:0];
                        q = {q[IDX_W-2:0], 1'b0};
                    end
                end
            end
            dv_rem_next[s+1] = r;
            dv_quo_next[s+1] = q;
        end
    end

    // last stage: ROM read and gain placement
    always_comb
    begin
        gain_t                cosv;
        gain_t                ga;
        gain_t                gb;
        logic [SPK_IDX_W-1:0] first;
        logic [SPK_IDX_W-1:0] second;
        cosv = COS_ROM[dv_quo_reg[DIV_STAGES]];
        case (dv_law_reg[DIV_STAGES])
            LAW_START:
            begin
                ga = cosv;
                gb = UNITY_Q15 - cosv;
            end
            LAW_END:
            begin
                gb = cosv;
                ga = UNITY_Q15 - cosv;
            end
            default:
            begin
                gb = dv_lin_reg[DIV_STAGES];
                ga = UNITY_Q15 - dv_lin_reg[DIV_STAGES];
            end
        endcase
        first  = dv_span_reg[DIV_STAGES];
        second = (dv_span_reg[DIV_STAGES] == SPAN_RB_LB) ? '0 : SPK_IDX_W'(first + 1'b1);
        for (int k = 0; k < SPEAKER_COUNT; k++)
        begin
            gain_next[k] = '0;
        end
        gain_next[first]  = ga;
        gain_next[second] = gb;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en[ST_THETA])
        begin
            theta_reg <= theta_next;
        end
        if (en[ST_SPAN])
        begin
            span_s1_reg <= span_s1_next;
            off_reg     <= off_next;
        end
        if (en[ST_FRAC])
        begin
            span_s2_reg <= span_s1_reg;
            frac_reg    <= FRAC_W'(prod >> FRAC_SHIFT);
        end
        if (en[ST_ZONE])
        begin
            dv_span_reg[0] <= span_s2_reg;
            dv_law_reg[0]  <= law_next;
            dv_lin_reg[0]  <= GAIN_W'(frac_reg >> 1);
            dv_rem_reg[0]  <= dv_rem_next[0];
            dv_quo_reg[0]  <= dv_quo_next[0];
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            if (en[ST_ZONE + s])
            begin
                dv_span_reg[s] <= dv_span_reg[s-1];
                dv_law_reg[s]  <= dv_law_reg[s-1];
                dv_lin_reg[s]  <= dv_lin_reg[s-1];
                dv_rem_reg[s]  <= dv_rem_next[s];
                dv_quo_reg[s]  <= dv_quo_next[s];
            end
        end
        if (en[ST_OUT])
        begin
            for (int k = 0; k < SPEAKER_COUNT; k++)
            begin
                gain_reg[k] <= gain_next[k];
            end
        end
    end

    assign gains.gain_left_back   = gain_reg[0];
    assign gains.gain_left_side   = gain_reg[1];
    assign gains.gain_left_front  = gain_reg[2];
    assign gains.gain_center      = gain_reg[3];
    assign gains.gain_right_front = gain_reg[4];
    assign gains.gain_right_side  = gain_reg[5];
    assign gains.gain_right_back  = gain_reg[6];

    // checks
    logic [GAIN_W+2:0]        gain_sum;
    logic [SPEAKER_COUNT-1:0] gain_nz;

    always_comb
    begin
        gain_sum = '0;
        for (int k = 0; k < SPEAKER_COUNT; k++)
        begin
            gain_sum   = gain_sum + (GAIN_W+3)'(gain_reg[k]);
            gain_nz[k] = gain_reg[k] != '0;
        end
    end

    a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT] |-> gain_sum == (GAIN_W+3)'(UNITY_Q15))
        else $error("gains do not sum to unity");

    a_gain_pair: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_OUT] |-> $countones(gain_nz) <= 2)
        else $error("more than two speakers driven");

    a_theta_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_THETA] |-> theta_reg < THETA_W'(FULL_TURN))
        else $error("wrapped angle out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_ZONE] && dv_law_reg[0] != LAW_LINEAR) |-> dv_rem_reg[0] < zone_reg)
        else $error("crossfade distance not inside zone");

endmodule
